// ===== rtl/mlp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mlp_pkg;

    localparam int MAX_LAYERS   = 4;
    localparam int MAX_WIDTH    = 16;
    localparam int TANH_ENTRIES = 1024;
    localparam int ACC_W        = 40;
    localparam int DIGIT_W      = 4;

    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] REG_WIDTH0      = 3'd1;
    localparam logic [2:0] REG_WIDTH1      = 3'd2;
    localparam logic [2:0] REG_WIDTH2      = 3'd3;
    localparam logic [2:0] REG_WIDTH3      = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ACC_INIT,
        ST_RD_WGT,
        ST_RD_ACT,
        ST_MUL,
        ST_MUL_WAIT,
        ST_ACT,
        ST_ACT_WAIT,
        ST_EMIT_RD,
        ST_EMIT,
        ST_ERR
    } mlp_state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } mac_ctrl_t;

    // Quotient of two nonnegative values by shift and subtract, elaboration only.
    function automatic longint udiv(input longint num, input longint den);
        longint q;
        longint rem;
        q   = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'sd1);
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // Bin center of table entry i, in signed 16-bit value space.
    function automatic int tanh_center(input int i, input int entries);
        return int'(udiv(longint'(2 * i + 1) * 65536, longint'(2 * entries))) - 32768;
    endfunction

    // round(4096*tanh(c/4096)) by the exact integer procedure, elaboration only.
    function automatic logic signed [15:0] tanh_q12(input int c);
        longint mag;
        longint z;
        longint e;
        longint t;
        longint num;
        longint den;
        longint r;
        longint one31;
        one31 = 64'sd1 << 31;
        mag = (c < 0) ? -c : c;
        z = (mag << 20) >>> 5;
        e = one31;
        t = one31;
        for (int n = 1; n <= 12; n++) begin
            t = udiv((t * z) >>> 31, longint'(n));
            if (n[0]) e = e - t;
            else e = e + t;
        end
        for (int n = 0; n < 5; n++) e = (e * e) >>> 31;
        num = (one31 - e) * 8192 + (one31 + e);
        den = 2 * (one31 + e);
        r = udiv(num, den);
        return (c < 0) ? 16'(-r) : 16'(r);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mlp_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Digit-serial multiply-accumulate: while busy, walks the multiplier four bits a cycle,
// adding one narrow partial product into a 40-bit accumulator per step.
module mlp_mac #(
    parameter int DATA_W  = 16,
    parameter int ACC_W   = mlp_pkg::ACC_W,
    parameter int DIGIT_W = mlp_pkg::DIGIT_W
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire mlp_pkg::mac_ctrl_t ctrl,
    input  wire                     clear,
    input  wire signed [DATA_W-1:0] mcand,
    input  wire signed [DATA_W-1:0] mplier,
    output logic                    done,
    output logic signed [ACC_W-1:0] acc
);
    localparam int STEPS = DATA_W / DIGIT_W;
    localparam int CW    = $clog2(STEPS + 1);

    logic [CW-1:0]            step_reg, step_next;
    logic [DATA_W-1:0]        mq_reg, mq_next;
    logic signed [ACC_W-1:0]  mc_reg, mc_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DIGIT_W:0]  digit;
    logic signed [ACC_W-1:0]  part;

    always_comb begin
        // top digit signed, lower digits unsigned
        if (step_reg == CW'(STEPS - 1))
            digit = {mq_reg[DIGIT_W-1], mq_reg[DIGIT_W-1:0]};
        else
            digit = {1'b0, mq_reg[DIGIT_W-1:0]};
        part      = mc_reg * ACC_W'(digit);
        step_next = step_reg;
        mq_next   = mq_reg;
        mc_next   = mc_reg;
        acc_next  = acc_reg;
        if (clear) acc_next = '0;
        if (ctrl.start) begin
            step_next = '0;
            mq_next   = mplier;
            mc_next   = ACC_W'(mcand);
        end else if (ctrl.busy && step_reg < CW'(STEPS)) begin
            acc_next  = acc_reg + part;
            mq_next   = mq_reg >> DIGIT_W;
            mc_next   = mc_reg <<< DIGIT_W;
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= CW'(STEPS);
            acc_reg  <= '0;
        end else begin
            step_reg <= step_next;
            acc_reg  <= acc_next;
        end
        mq_reg <= mq_next;
        mc_reg <= mc_next;
    end

    assign done = (step_reg == CW'(STEPS));
    assign acc  = acc_reg;
endmodule
`default_nettype wire

// ===== rtl/mlp_tanh_inference_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Evaluation: the last sample starts it; each neuron takes a bias term and a tanh lookup, plus
// per source two memory reads and a four-digit serial MAC, for up to four layers of 16; each
// result beat then takes its own activation read. Throughput: weights and samples back to
// back; nothing taken while evaluating or while a result waits. Reset: synchronous, active
// low; a clearing pass zeroes both memories (activations first), during which no beat is
// accepted.
module mlp_tanh_inference_unit #(
    parameter int MAX_LAYERS   = mlp_pkg::MAX_LAYERS,
    parameter int MAX_WIDTH    = mlp_pkg::MAX_WIDTH,
    parameter int TANH_ENTRIES = mlp_pkg::TANH_ENTRIES
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [4:0]  cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata: layer_sel[1:0], dest_index[5:2], src_index[10:6], weight[26:11],
    // sample[42:27], zero fill [47:43]
    input  wire  [47:0] s_tdata,
    input  wire         s_tuser,   // kind
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata: out_index[3:0], out_value[17:4], zero fill [23:18]
    output logic [23:0] m_tdata,
    output logic        m_tuser,   // status
    output logic        m_tlast
);
    localparam int WDEPTH = (MAX_LAYERS - 1) * MAX_WIDTH * (MAX_WIDTH + 1);
    localparam int ADEPTH = MAX_LAYERS * MAX_WIDTH;
    localparam int WA     = $clog2(WDEPTH);
    localparam int AA     = $clog2(ADEPTH);
    localparam int LW     = $clog2(MAX_LAYERS);
    localparam int NW     = $clog2(MAX_WIDTH + 1);
    localparam int TW     = $clog2(TANH_ENTRIES);
    localparam int LLIM   = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;

    // tanh table, built at elaboration
    typedef logic signed [15:0] lut_t [TANH_ENTRIES];
    function automatic logic signed [15:0] build_lut_entry(input int i);
        return mlp_pkg::tanh_q12(mlp_pkg::tanh_center(i, TANH_ENTRIES));
    endfunction
    function automatic lut_t build_lut();
        lut_t t;
        for (int i = 0; i < TANH_ENTRIES; i++) t[i] = build_lut_entry(i);
        return t;
    endfunction
    localparam lut_t TANH_LUT = build_lut();

    // register file
    logic [2:0] layer_count_reg;
    logic [4:0] width_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_count_reg <= 3'd3;
            width_reg[0]    <= 5'd8;
            width_reg[1]    <= 5'd8;
            width_reg[2]    <= 5'd4;
            width_reg[3]    <= 5'd4;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mlp_pkg::REG_LAYER_COUNT: layer_count_reg <= cfg_data[2:0];
                mlp_pkg::REG_WIDTH0:      width_reg[0] <= cfg_data;
                mlp_pkg::REG_WIDTH1:      width_reg[1] <= cfg_data;
                mlp_pkg::REG_WIDTH2:      width_reg[2] <= cfg_data;
                mlp_pkg::REG_WIDTH3:      width_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [NW-1:0] eff_w(input logic [4:0] v);
        if (v == 5'd0) return NW'(1);
        if (32'(v) > MAX_WIDTH) return NW'(MAX_WIDTH);
        return NW'(v);
    endfunction

    logic [2:0] eff_layers;
    always_comb begin
        eff_layers = layer_count_reg;
        if (eff_layers < 3'd2) eff_layers = 3'd2;
        if (32'(eff_layers) > LLIM) eff_layers = 3'(LLIM);
    end

    // input field unpack
    logic [1:0]         in_layer;
    logic [3:0]         in_dest;
    logic [4:0]         in_src;
    logic signed [15:0] in_weight;
    logic signed [15:0] in_sample;
    assign in_layer  = s_tdata[1:0];
    assign in_dest   = s_tdata[5:2];
    assign in_src    = s_tdata[10:6];
    assign in_weight = s_tdata[26:11];
    assign in_sample = s_tdata[42:27];

    // memories
    logic signed [15:0] wmem [WDEPTH];
    logic signed [15:0] amem [ADEPTH];
    logic signed [15:0] wrd_reg, ard_reg;
    logic               wwe, awe;
    logic [WA-1:0]      wwa, wra;
    logic [AA-1:0]      awa, ara;
    logic signed [15:0] wwd, awd;

    always_ff @(posedge aclk) begin
        if (wwe) wmem[wwa] <= wwd;
        wrd_reg <= wmem[wra];
    end
    always_ff @(posedge aclk) begin
        if (awe) amem[awa] <= awd;
        ard_reg <= amem[ara];
    end

    // control state
    mlp_pkg::mlp_state_t state_reg, state_next;
    logic [WA:0]    clr_reg, clr_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic [LW-1:0]  lay_reg, lay_next;
    logic [NW-1:0]  d_reg, d_next;
    logic [NW-1:0]  s_reg, s_next;
    logic signed [15:0] wl_reg, wl_next;
    logic [3:0]     oidx_reg, oidx_next;
    logic [13:0]    oval_reg, oval_next;
    logic           olast_reg, olast_next, ostat_reg, ostat_next;
    logic           ovalid_reg, ovalid_next;
    logic [TW-1:0]  tidx;
    logic signed [15:0] tanh_reg;

    mlp_pkg::mac_ctrl_t mctl;
    logic               mclear, mdone;
    logic signed [15:0] mcand, mplier;
    logic signed [mlp_pkg::ACC_W-1:0] acc;

    mlp_mac u_mac (
        .aclk(aclk), .aresetn(aresetn), .ctrl(mctl), .clear(mclear),
        .mcand(mcand), .mplier(mplier), .done(mdone), .acc(acc)
    );

    logic [NW-1:0] pw, cw;
    logic [mlp_pkg::ACC_W-13:0] shifted;
    logic signed [15:0] sat;

    function automatic logic [WA-1:0] widx(input logic [LW-1:0] l,
                                           input logic [NW-1:0] d,
                                           input logic [NW-1:0] s);
        return WA'((32'(l) - 1) * MAX_WIDTH * (MAX_WIDTH + 1) +
                   32'(d) * (MAX_WIDTH + 1) + 32'(s));
    endfunction

    always_comb begin
        pw = eff_w(width_reg[2'(lay_reg - 1'b1)]);
        cw = eff_w(width_reg[2'(lay_reg)]);
        shifted = acc[mlp_pkg::ACC_W-1:12];
        // saturate the floor-shifted sum to 16 bits
        if (!shifted[$bits(shifted)-1] && |shifted[$bits(shifted)-2:15])
            sat = 16'sh7fff;
        else if (shifted[$bits(shifted)-1] && !(&shifted[$bits(shifted)-2:15]))
            sat = -16'sh8000;
        else
            sat = shifted[15:0];
        // index by top bits with the sign inverted
        tidx = {~sat[15], sat[14 -: TW-1]};
    end

    // registered table read
    always_ff @(posedge aclk) begin
        tanh_reg <= TANH_LUT[tidx];
    end

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cnt_next    = cnt_reg;
        lay_next    = lay_reg;
        d_next      = d_reg;
        s_next      = s_reg;
        wl_next     = wl_reg;
        oidx_next   = oidx_reg;
        oval_next   = oval_reg;
        olast_next  = olast_reg;
        ostat_next  = ostat_reg;
        ovalid_next = ovalid_reg;
        s_tready    = 1'b0;
        wwe = 1'b0; wwa = '0; wwd = '0; wra = '0;
        awe = 1'b0; awa = '0; awd = '0; ara = '0;
        mctl   = '0;
        mclear = 1'b0;
        mcand  = wl_reg;
        mplier = ard_reg;

        if (ovalid_reg && m_tready) ovalid_next = 1'b0;

        unique case (state_reg)
            mlp_pkg::ST_CLEAR: begin
                // sweep both memories to zero
                if (clr_reg < (WA+1)'(WDEPTH)) begin
                    wwe = 1'b1; wwa = clr_reg[WA-1:0];
                end
                if (clr_reg < (WA+1)'(ADEPTH)) begin
                    awe = 1'b1; awa = AA'(clr_reg);
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (WA+1)'(WDEPTH - 1)) state_next = mlp_pkg::ST_IDLE;
            end
            mlp_pkg::ST_IDLE: begin
                s_tready = !ovalid_reg;
                if (s_tvalid && s_tready) begin
                    if (s_tuser == mlp_pkg::KIND_WEIGHT) begin
                        if (in_layer != 2'd0 && 32'(in_layer) < MAX_LAYERS &&
                            32'(in_src) <= MAX_WIDTH) begin
                            wwe = 1'b1;
                            wwa = widx(LW'(in_layer), NW'(in_dest), NW'(in_src));
                            wwd = in_weight;
                        end
                    end else begin
                        if (32'(cnt_reg) < MAX_WIDTH) begin
                            awe = 1'b1; awa = AA'(cnt_reg); awd = in_sample;
                        end
                        cnt_next = (cnt_reg == 5'd31) ? cnt_reg : cnt_reg + 1'b1;
                        if (s_tlast) begin
                            cnt_next = '0;
                            if (NW'(cnt_reg) + NW'(1) == eff_w(width_reg[0]) &&
                                32'(cnt_reg) < MAX_WIDTH) begin
                                lay_next   = LW'(1);
                                d_next     = '0;
                                state_next = mlp_pkg::ST_ACC_INIT;
                            end else begin
                                state_next = mlp_pkg::ST_ERR;
                            end
                        end
                    end
                end
            end
            mlp_pkg::ST_ERR: begin
                oidx_next   = '0;
                oval_next   = '0;
                olast_next  = 1'b1;
                ostat_next  = 1'b1;
                ovalid_next = 1'b1;
                state_next  = mlp_pkg::ST_IDLE;
            end
            mlp_pkg::ST_ACC_INIT: begin
                // start with bias weight times 1.0
                mclear = 1'b1;
                s_next = '0;
                wra    = widx(lay_reg, d_reg, pw);
                state_next = mlp_pkg::ST_RD_WGT;
            end
            mlp_pkg::ST_RD_WGT: begin
                wra = widx(lay_reg, d_reg, s_reg);
                if (s_reg == '0) begin
                    mctl.start = 1'b1;
                    mcand  = wrd_reg;
                    mplier = 16'sh1000;
                    state_next = mlp_pkg::ST_MUL_WAIT;
                end else begin
                    // hold the weight of source s-1 read during the last MAC cycle
                    wl_next    = wrd_reg;
                    state_next = mlp_pkg::ST_RD_ACT;
                end
            end
            mlp_pkg::ST_RD_ACT: begin
                ara = AA'(32'(lay_reg - 1'b1) * MAX_WIDTH + 32'(s_reg - 1'b1));
                state_next = mlp_pkg::ST_MUL;
            end
            mlp_pkg::ST_MUL: begin
                mctl.start = 1'b1;
                state_next = mlp_pkg::ST_MUL_WAIT;
            end
            mlp_pkg::ST_MUL_WAIT: begin
                mctl.busy = 1'b1;
                if (mdone && !mctl.start) begin
                    if (s_reg == pw) begin
                        state_next = mlp_pkg::ST_ACT;
                    end else begin
                        s_next = s_reg + 1'b1;
                        wra    = widx(lay_reg, d_reg, s_reg);
                        state_next = mlp_pkg::ST_RD_WGT;
                    end
                end
            end
            mlp_pkg::ST_ACT: begin
                // table output registers at the end of this cycle
                state_next = mlp_pkg::ST_ACT_WAIT;
            end
            mlp_pkg::ST_ACT_WAIT: begin
                awe = 1'b1;
                awa = AA'(32'(lay_reg) * MAX_WIDTH + 32'(d_reg));
                awd = tanh_reg;
                if (d_reg == cw - 1'b1) begin
                    d_next = '0;
                    if (32'(lay_reg) == 32'(eff_layers) - 1) begin
                        state_next = mlp_pkg::ST_EMIT_RD;
                    end else begin
                        lay_next   = lay_reg + 1'b1;
                        state_next = mlp_pkg::ST_ACC_INIT;
                    end
                end else begin
                    d_next     = d_reg + 1'b1;
                    state_next = mlp_pkg::ST_ACC_INIT;
                end
            end
            mlp_pkg::ST_EMIT_RD: begin
                ara = AA'(32'(lay_reg) * MAX_WIDTH + 32'(d_reg));
                if (!ovalid_reg || m_tready) state_next = mlp_pkg::ST_EMIT;
            end
            mlp_pkg::ST_EMIT: begin
                oidx_next   = d_reg[3:0];
                oval_next   = ard_reg[13:0];
                olast_next  = (d_reg == cw - 1'b1);
                ostat_next  = 1'b0;
                ovalid_next = 1'b1;
                if (d_reg == cw - 1'b1) begin
                    state_next = mlp_pkg::ST_IDLE;
                end else begin
                    d_next     = d_reg + 1'b1;
                    state_next = mlp_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = mlp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mlp_pkg::ST_CLEAR;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
        lay_reg   <= lay_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        wl_reg    <= wl_next;
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
        ostat_reg <= ostat_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {6'd0, oval_reg, oidx_reg};
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;
endmodule
`default_nettype wire

// ===== test/mlp_tanh_inference_unit_tb.sv =====
`timescale 1ns / 1ps
module mlp_tanh_inference_unit_tb;

    localparam int  WSTORE_DEPTH   = (mlp_pkg::MAX_LAYERS - 1) * mlp_pkg::MAX_WIDTH *
                                     (mlp_pkg::MAX_WIDTH + 1);
    localparam int  STALL_LIMIT    = 120000;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_COUNT_ERR = 1'b1;

    // One result beat as the block presents it
    typedef struct {
        logic [3:0]  idx;
        logic [13:0] val;
        logic        last;
        logic        status;
    } neuron_out_t;

    // One row of the directed table; typed rows carry their own expectation
    typedef struct {
        logic        kind;
        logic [1:0]  lsel;
        logic [3:0]  dest;
        logic [4:0]  src;
        logic [15:0] wgt;
        logic [15:0] smp;
        logic        last;
        bit          typed;
        logic [13:0] t_val;
        logic        t_status;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // layer_sel, dest_index, src_index, weight, sample, zero fill
    logic        s_tuser = 1'b0; // kind
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;       // out_index, out_value, zero fill
    logic        m_tuser;       // status
    logic        m_tlast;

    // Shadow of the network: weights, activations, sample counter, registers
    logic signed [15:0] net_weights [WSTORE_DEPTH];
    logic signed [15:0] net_acts [mlp_pkg::MAX_LAYERS * mlp_pkg::MAX_WIDTH];
    logic signed [15:0] tanh_lut [mlp_pkg::TANH_ENTRIES];
    int unsigned        samples_seen;
    logic [2:0]         layers_reg;
    logic [4:0]         width_reg [4];

    neuron_out_t pending_outputs [$];
    stim_row_t   directed_rows [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;

    mlp_tanh_inference_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #6 aclk = ~aclk;

    // Integer tanh in Q4.12: truncated series for exp(-2|x|/32), squared five times
    function automatic logic signed [15:0] q12_tanh(input longint c);
        longint one, mag, z, ex, term, num, den, r;
        one = longint'(1) << 31;
        mag = (c < 0) ? -c : c;
        z = (mag << 20) >>> 5;
        ex = one;
        term = one;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * z) >>> 31) / n;
            ex = (n % 2 == 1) ? ex - term : ex + term;
        end
        for (int n = 0; n < 5; n++) ex = (ex * ex) >>> 31;
        num = (one - ex) * 8192 + (one + ex);
        den = 2 * (one + ex);
        r = num / den;
        return (c < 0) ? 16'(-r) : 16'(r);
    endfunction

    function automatic int clamp_layers();
        int v;
        v = layers_reg;
        if (v < 2) v = 2;
        if (v > mlp_pkg::MAX_LAYERS) v = mlp_pkg::MAX_LAYERS;
        return v;
    endfunction

    function automatic int clamp_width(input int layer);
        int v;
        v = width_reg[layer];
        if (v < 1) v = 1;
        if (v > mlp_pkg::MAX_WIDTH) v = mlp_pkg::MAX_WIDTH;
        return v;
    endfunction

    function automatic int weight_addr(input int layer, input int dest, input int src);
        return ((layer - 1) * mlp_pkg::MAX_WIDTH + dest) * (mlp_pkg::MAX_WIDTH + 1) + src;
    endfunction

    // Floor-shift, saturate, look up the tanh bin
    function automatic logic signed [15:0] squash(input longint acc);
        longint s;
        s = acc >>> 12;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return tanh_lut[(s + 32768) >> 6];
    endfunction

    // Append one expected result beat
    task automatic expect_beat(input neuron_out_t o);
        pending_outputs.insert(pending_outputs.size(), o);
    endtask

    // Append one row to the directed table
    task automatic add_row(input stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Apply one accepted input beat to the shadow network, queue its outputs
    task automatic forward_pass(input stim_row_t it);
        int layers, pw, w;
        longint acc;
        neuron_out_t o;
        if (it.kind == mlp_pkg::KIND_WEIGHT) begin
            if (it.lsel >= 1 && it.lsel < mlp_pkg::MAX_LAYERS && it.src <= mlp_pkg::MAX_WIDTH)
                net_weights[weight_addr(it.lsel, it.dest, it.src)] = it.wgt;
            return;
        end
        if (samples_seen < mlp_pkg::MAX_WIDTH) net_acts[samples_seen] = it.smp;
        if (samples_seen < 31) samples_seen++;
        if (!it.last) return;
        if (samples_seen != clamp_width(0)) begin
            samples_seen = 0;
            o.idx = '0; o.val = '0; o.last = 1'b1; o.status = STATUS_COUNT_ERR;
            expect_beat(o);
            return;
        end
        samples_seen = 0;
        layers = clamp_layers();
        for (int l = 1; l < layers; l++) begin
            pw = clamp_width(l - 1);
            w = clamp_width(l);
            for (int d = 0; d < w; d++) begin
                acc = longint'(net_weights[weight_addr(l, d, pw)]) * 4096;
                for (int s = 0; s < pw; s++)
                    acc += longint'(net_weights[weight_addr(l, d, s)])
                         * longint'(net_acts[(l - 1) * mlp_pkg::MAX_WIDTH + s]);
                net_acts[l * mlp_pkg::MAX_WIDTH + d] = squash(acc);
            end
        end
        w = clamp_width(layers - 1);
        for (int d = 0; d < w; d++) begin
            o.idx = d[3:0];
            o.val = net_acts[(layers - 1) * mlp_pkg::MAX_WIDTH + d][13:0];
            o.last = (d == w - 1);
            o.status = STATUS_OK;
            expect_beat(o);
        end
    endtask

    // Offer one beat, holding it until the block takes it; gaps first at random
    task automatic send_beat(input stim_row_t it);
        int depth;
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tlast  <= it.last;
        s_tdata  <= {5'b0, it.smp, it.wgt, it.src, it.dest, it.lsel};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        depth = pending_outputs.size();
        forward_pass(it);
        if (it.typed) begin
            while (pending_outputs.size() > depth) void'(pending_outputs.pop_back());
            expect_beat('{4'd0, it.t_val, 1'b1, it.t_status});
        end
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outputs.size() != 0) @(posedge aclk);
        // weight beats leave no result; give the block a moment to settle
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == mlp_pkg::REG_LAYER_COUNT) layers_reg = val[2:0];
        else if (idx <= mlp_pkg::REG_WIDTH3) width_reg[idx - mlp_pkg::REG_WIDTH0] = val;
        @(posedge aclk);
    endtask

    task automatic set_topology(input logic [4:0] lc, input logic [4:0] w0,
                                input logic [4:0] w1, input logic [4:0] w2,
                                input logic [4:0] w3);
        write_reg(mlp_pkg::REG_LAYER_COUNT, lc);
        write_reg(mlp_pkg::REG_WIDTH0, w0);
        write_reg(mlp_pkg::REG_WIDTH1, w1);
        write_reg(mlp_pkg::REG_WIDTH2, w2);
        write_reg(mlp_pkg::REG_WIDTH3, w3);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_q12();
        if ($urandom_range(1) == 1) return 16'($signed($urandom_range(8192)) - 4096);
        return 16'($urandom);
    endfunction

    function automatic stim_row_t mk_row(input logic kind, input logic [1:0] ls,
                                         input logic [3:0] di, input logic [4:0] si,
                                         input logic [15:0] w, input logic [15:0] smp,
                                         input logic last);
        stim_row_t r;
        r = '{kind, ls, di, si, w, smp, last, 1'b0, 14'd0, STATUS_OK};
        return r;
    endfunction

    // One well-formed run: weights aimed at the live topology, then a full vector
    task automatic good_run(inout int sent);
        int layers, l;
        layers = clamp_layers();
        repeat ($urandom_range(0, 10)) begin
            l = $urandom_range(1, layers - 1);
            send_beat(mk_row(mlp_pkg::KIND_WEIGHT, l[1:0],
                             4'($urandom_range(clamp_width(l) - 1)),
                             5'($urandom_range(clamp_width(l - 1))), pick_q12(), 16'($urandom),
                             1'($urandom)));
            sent++;
        end
        for (int i = 0; i < clamp_width(0); i++) begin
            send_beat(mk_row(mlp_pkg::KIND_SAMPLE, 2'($urandom), 4'($urandom), 5'($urandom),
                             16'($urandom), pick_q12(), i == clamp_width(0) - 1));
            sent++;
        end
    endtask

    // Noise: raw weight beats with any field, or a vector of random length
    task automatic broken_run(inout int sent);
        int n;
        if ($urandom_range(1) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                send_beat(mk_row(mlp_pkg::KIND_WEIGHT, 2'($urandom), 4'($urandom),
                                 5'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)));
                sent++;
            end
        end else begin
            n = ($urandom_range(9) == 0) ? 33 : $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
                send_beat(mk_row(mlp_pkg::KIND_SAMPLE, 2'($urandom), 4'($urandom),
                                 5'($urandom), 16'($urandom), 16'($urandom), i == n - 1));
                sent++;
            end
        end
    endtask

    // Receiver: stall at the phase's rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: compare each beat against the oldest expectation
    always @(posedge aclk) begin
        neuron_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: idx=%0d val=%h last=%b status=%b",
                             m_tdata[3:0], m_tdata[17:4], m_tlast, m_tuser);
            end else begin
                want = pending_outputs.pop_front();
                if (m_tdata[3:0] !== want.idx || m_tdata[17:4] !== want.val ||
                    m_tlast !== want.last || m_tuser !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: want idx=%0d val=%h last=%b status=%b, %s",
                                 want.idx, want.val, want.last, want.status,
                                 $sformatf("got idx=%0d val=%h last=%b status=%b",
                                           m_tdata[3:0], m_tdata[17:4], m_tlast, m_tuser));
                end
            end
        end
    end

    // Watchdog: bail out when no beat moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("mlp_tanh_inference_unit verification failed");
            $finish;
        end
    end

    initial begin
        int sent;
        for (int i = 0; i < mlp_pkg::TANH_ENTRIES; i++)
            tanh_lut[i] = q12_tanh(((2 * i + 1) * 65536) / (2 * mlp_pkg::TANH_ENTRIES)
                                   - 32768);
        foreach (net_weights[i]) net_weights[i] = '0;
        foreach (net_acts[i]) net_acts[i] = '0;
        samples_seen = 0;
        layers_reg = 3'd3;
        width_reg = '{5'd8, 5'd8, 5'd4, 5'd4};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset topology (3 layers, 8-8-4)
        // short vector on last: count error
        add_row('{mlp_pkg::KIND_SAMPLE, 2'd0, 4'd0, 5'd0, 16'd0, 16'h7fff, 1'b1,
                  1'b1, 14'd0, STATUS_COUNT_ERR});
        // weight beats: ignored layer 0, src beyond bias, then extremes that stick
        add_row(mk_row(mlp_pkg::KIND_WEIGHT, 2'd0, 4'd1, 5'd1, 16'h7fff, 16'd0, 1'b1));
        add_row(mk_row(mlp_pkg::KIND_WEIGHT, 2'd1, 4'd0, 5'd31, 16'h7fff, 16'd0, 1'b0));
        add_row(mk_row(mlp_pkg::KIND_WEIGHT, 2'd1, 4'd15, 5'd16, 16'h8000, 16'd0, 1'b0));
        add_row(mk_row(mlp_pkg::KIND_WEIGHT, 2'd1, 4'd0, 5'd0, 16'h7fff, 16'd0, 1'b0));
        add_row(mk_row(mlp_pkg::KIND_WEIGHT, 2'd1, 4'd1, 5'd8, 16'h8000, 16'd0, 1'b0));
        add_row(mk_row(mlp_pkg::KIND_WEIGHT, 2'd2, 4'd0, 5'd0, 16'h7fff, 16'd0, 1'b0));
        add_row(mk_row(mlp_pkg::KIND_WEIGHT, 2'd2, 4'd3, 5'd8, 16'h1000, 16'd0, 1'b0));
        add_row(mk_row(mlp_pkg::KIND_WEIGHT, 2'd3, 4'd15, 5'd16, 16'h7fff, 16'd0, 1'b0));
        // full vector of extremes, evaluated through the predictor
        add_row(mk_row(mlp_pkg::KIND_SAMPLE, 2'd3, 4'd15, 5'd31, 16'hffff, 16'h7fff, 1'b0));
        add_row(mk_row(mlp_pkg::KIND_SAMPLE, 2'd0, 4'd0, 5'd0, 16'd0, 16'h8000, 1'b0));
        for (int i = 0; i < 5; i++)
            add_row(mk_row(mlp_pkg::KIND_SAMPLE, 2'd0, 4'd0, 5'd0, 16'd0,
                           16'(i * 1000 - 2000), 1'b0));
        add_row(mk_row(mlp_pkg::KIND_SAMPLE, 2'd0, 4'd0, 5'd0, 16'd0, 16'h0000, 1'b1));
        // two-sample vector on last: count error
        add_row(mk_row(mlp_pkg::KIND_SAMPLE, 2'd0, 4'd0, 5'd0, 16'd0, 16'h1234, 1'b0));
        add_row('{mlp_pkg::KIND_SAMPLE, 2'd0, 4'd0, 5'd0, 16'd0, 16'h4321, 1'b1,
                  1'b1, 14'd0, STATUS_COUNT_ERR});
        foreach (directed_rows[i]) send_beat(directed_rows[i]);

        // Pause until everything is back before touching the registers
        drain_outputs();

        // Random part: several topologies, each under its own idling mix
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_topology(5'd2, 5'd1, 5'd1, 5'd1, 5'd1);
                1: set_topology(5'd3, 5'd4, 5'd6, 5'd3, 5'd2);
                2: set_topology(5'd4, 5'd16, 5'd16, 5'd16, 5'd16);
                3: set_topology(5'd0, 5'd0, 5'd0, 5'd0, 5'd0);       // clamp to low bounds
                4: set_topology(5'd7, 5'd31, 5'd2, 5'd3, 5'd31);     // clamp to high bounds
                5: set_topology(5'd4, 5'd5, 5'd7, 5'd9, 5'd11);
                6: set_topology(5'd3, 5'd3, 5'd10, 5'd12, 5'd5);
                default: begin
                    write_reg(3'd5, 5'd31);                          // past the list: ignored
                    set_topology(5'd2, 5'd6, 5'd14, 5'd1, 5'd1);
                end
            endcase
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
                default: begin send_gap_pct = 33; recv_stall_pct = 33; end
            endcase
            sent = 0;
            while (sent < ((phase == 2) ? 25 : 45)) begin
                if ($urandom_range(99) < 70) good_run(sent);
                else broken_run(sent);
            end
            drain_outputs();
        end

        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_outputs.size() == 0) begin
            $display("mlp_tanh_inference_unit verification clean");
        end else begin
            $display("mlp_tanh_inference_unit verification failed");
        end
        $finish;
    end

endmodule
